>>> src/tehl_pkg.sv
// Shared types and constants for the timestamped event hold lookup.
// Holds the controller/datapath command and status structs and reset values.
// No dependencies.
`timescale 1ns / 1ps

package tehl_pkg;

    // Default ring depth handed to the top level.
    localparam int RING_DEPTH_DEF = 16;

    // Configuration register indexes.
    localparam logic CFG_AMPLITUDE   = 1'b0;
    localparam logic CFG_TIME_OFFSET = 1'b1;

    // Register reset values, signed Q16.16.
    localparam logic signed [31:0] AMPLITUDE_RST   = 32'sh0001_0000;
    localparam logic signed [31:0] TIME_OFFSET_RST = 32'sh0000_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;    // write zero to the next ring entry of the clearing pass
        logic rec;    // store a recorded item at the advanced write pointer
        logic start;  // latch query time and flags, aim the read pointer at the newest entry
        logic rd;     // read the entry at the read pointer and step it back
        logic ev;     // evaluate the entry read in the previous cycle
        logic mul;    // form the product of amplitude and the held value
        logic load;   // load the saturated product, or zero for an inactive source, into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;  // the clearing pass is at the last entry
        logic stop;      // the evaluated entry ends the walk
    } t_dp_sts;

endpackage

>>> src/timestamped_event_hold_lookup.sv
// Top level of the timestamped event hold lookup: joins controller and datapath.
// Depends on tehl_pkg, tehl_ctrl and tehl_dp.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-------------------------------------
//   in       | input     | i_in_valid / o_in_stall   | command, event_time, sample_value,
//            |           |                           | source_active
//   out      | output    | o_out_valid / i_out_stall | result_value
//   cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A record item is written to the ring when it is accepted. A query item is accepted,
// then walks the ring from the newest entry back, reading each entry through the single
// registered read port and then comparing it, until the walk ends; it then multiplies
// and loads the output register. An inactive query skips the walk. After reset a clearing
// pass writes the ring to zero, and no item is accepted until it ends. A stalled result
// holds in the output register; the next item is accepted meanwhile and its result waits behind it.
`timescale 1ns / 1ps

module timestamped_event_hold_lookup
    import tehl_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic signed [31:0] i_event_time,
    input  logic signed [31:0] i_sample_value,
    input  logic               i_source_active,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_result_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration registers take a write in any cycle.
    assign o_cfg_ready = 1'b1;

    tehl_ctrl #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_command       (i_command),
        .i_source_active (i_source_active),
        .i_out_stall     (i_out_stall),
        .i_sts           (sts),
        .o_cmd           (cmd),
        .o_in_stall      (o_in_stall),
        .o_out_valid     (o_out_valid)
    );

    tehl_dp #(
        .RING_DEPTH(RING_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_event_time    (i_event_time),
        .i_sample_value  (i_sample_value),
        .i_source_active (i_source_active),
        .i_cfg_wr        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_value  (o_result_value)
    );

endmodule

>>> src/tehl_dp.sv
// Datapath of the timestamped event hold lookup: ring memory, walk compare,
// configuration registers, multiplier and output register.
// Depends on tehl_pkg.
`timescale 1ns / 1ps

module tehl_dp
    import tehl_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic signed [31:0] i_event_time,
    input  logic signed [31:0] i_sample_value,
    input  logic               i_source_active,
    input  logic               i_cfg_wr,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic signed [31:0] o_result_value
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

    // Ring storage: time in the upper half, value in the lower half.
    logic [63:0]        r_ring [RING_DEPTH];
    logic [63:0]        r_rdata;
    logic [AW-1:0]      r_wi;
    logic [AW-1:0]      r_raddr;
    logic [AW-1:0]      r_caddr;

    logic signed [31:0] r_amp;
    logic signed [31:0] r_toff;

    logic signed [31:0] r_qtime;
    logic               r_active;
    logic               r_have;
    logic               r_seen;
    logic [31:0]        r_best;
    logic signed [31:0] r_cval;
    logic signed [63:0] r_prod;

    logic [AW-1:0]      wi_next;
    logic [AW-1:0]      raddr_prev;
    logic signed [32:0] qsum;
    logic signed [31:0] qtime;
    logic signed [31:0] e_time;
    logic signed [31:0] e_val;
    logic signed [32:0] delta;
    logic               qual;
    logic               closer;
    logic signed [31:0] sat_prod;

    // Pointer stepping with wrap for any depth.
    assign wi_next    = (r_wi == LAST) ? '0 : r_wi + 1'b1;
    assign raddr_prev = (r_raddr == '0) ? LAST : r_raddr - 1'b1;

    // Query time plus offset, saturated to 32 bits.
    assign qsum = 33'(i_event_time) + 33'(r_toff);
    always_comb begin
        if (qsum[32] != qsum[31]) begin
            qtime = qsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            qtime = qsum[31:0];
        end
    end

    // Compare of the entry read in the previous cycle against the query time.
    assign e_time = r_rdata[63:32];
    assign e_val  = r_rdata[31:0];
    assign qual   = (e_time <= r_qtime);
    assign delta  = 33'(r_qtime) - 33'(e_time);
    assign closer = !r_have || (delta[31:0] < r_best);

    assign o_sts.stop     = i_cmd.ev && qual && !closer;
    assign o_sts.clr_last = (r_caddr == LAST);

    // Floor shift by 16 is the arithmetic shift; saturate when bits 63..47 differ.
    always_comb begin
        if ((r_prod[63:47] != '0) && (r_prod[63:47] != '1)) begin
            sat_prod = r_prod[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_prod = r_prod[47:16];
        end
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_ring[r_caddr] <= '0;
        end else if (i_cmd.rec) begin
            r_ring[wi_next] <= {i_event_time, i_sample_value};
        end
        if (i_cmd.rd) begin
            r_rdata <= r_ring[r_raddr];
        end
    end

    // Pointers and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi    <= '0;
            r_caddr <= '0;
            r_raddr <= '0;
            r_amp   <= AMPLITUDE_RST;
            r_toff  <= TIME_OFFSET_RST;
        end else begin
            if (i_cmd.clr && (r_caddr != LAST)) begin
                r_caddr <= r_caddr + 1'b1;
            end
            if (i_cmd.rec) begin
                r_wi <= wi_next;
            end
            if (i_cmd.start) begin
                r_raddr <= r_wi;
            end else if (i_cmd.rd) begin
                r_raddr <= raddr_prev;
            end
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    CFG_AMPLITUDE:   r_amp  <= i_cfg_data;
                    CFG_TIME_OFFSET: r_toff <= i_cfg_data;
                    default:         r_amp  <= r_amp;
                endcase
            end
        end
    end

    // Walk state: closest qualifying entry so far, and the newest value as fallback.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_seen <= 1'b0;
        end else if (i_cmd.start) begin
            r_have <= 1'b0;
            r_seen <= 1'b0;
        end else if (i_cmd.ev) begin
            r_seen <= 1'b1;
            if (qual && closer) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_qtime  <= qtime;
            r_active <= i_source_active;
        end
        if (i_cmd.ev) begin
            if (qual && closer) begin
                r_best <= delta[31:0];
                r_cval <= e_val;
            end else if (!r_seen) begin
                r_cval <= e_val;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= r_amp * r_cval;
        end
        if (i_cmd.load) begin
            o_result_value <= r_active ? sat_prod : 32'sh0;
        end
    end

endmodule

>>> src/tehl_ctrl.sv
// Controller of the timestamped event hold lookup: clearing pass, item
// acceptance, ring walk sequencing and output handshake.
// Depends on tehl_pkg.
`timescale 1ns / 1ps

module tehl_ctrl
    import tehl_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_command,
    input  logic    i_source_active,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    localparam int CW = $clog2(RING_DEPTH + 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [CW-1:0] r_nrd;
    logic [CW-1:0] n_nrd;
    logic [CW-1:0] r_nev;
    logic [CW-1:0] n_nev;
    logic          r_out_vld;
    logic          n_out_vld;
    logic          in_acc;
    logic          out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_vld || !i_out_stall;

    // Next state, walk counters and datapath commands.
    always_comb begin
        n_state   = r_state;
        n_nrd     = r_nrd;
        n_nev     = r_nev;
        o_cmd     = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_command) begin
                        o_cmd.start = 1'b1;
                        n_nrd       = '0;
                        n_nev       = '0;
                        n_state     = i_source_active ? S_WALK : S_MUL;
                    end else begin
                        o_cmd.rec = 1'b1;
                    end
                end
            end
            S_WALK: begin
                // A read issued in one cycle is evaluated in the next.
                if (r_nrd != CW'(RING_DEPTH)) begin
                    o_cmd.rd = 1'b1;
                    n_nrd    = r_nrd + 1'b1;
                end
                if (r_nev != r_nrd) begin
                    o_cmd.ev = 1'b1;
                    n_nev    = r_nev + 1'b1;
                    if (i_sts.stop || (r_nev == CW'(RING_DEPTH - 1))) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid: set on load, cleared when the item is taken.
    always_comb begin
        if (o_cmd.load) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_nrd     <= '0;
            r_nev     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_nrd     <= n_nrd;
            r_nev     <= n_nev;
            r_out_vld <= n_out_vld;
        end
    end

    // Evaluations never run ahead of reads, and trail them by at most one.
    a_ev_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_nev == r_nrd) || (r_nev + 1'b1 == r_nrd)))
        else $error("walk evaluation count out of step with reads");

    // A result is loaded only into a free output register.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (!r_out_vld || !i_out_stall))
        else $error("output register overwritten");

    // The clearing pass ends in idle once the last entry is written.
    a_clr_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLR) && i_sts.clr_last) |=> (r_state == S_IDLE))
        else $error("clearing pass did not end");

    // No ring write may happen while a query is being walked.
    a_no_rec_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.rec || o_cmd.clr) |-> !(o_cmd.rd || o_cmd.ev))
        else $error("ring written during a walk");

endmodule
